### hdl/ncle_pkg.sv
package ncle_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [1:0] reg_index_type;

   localparam kind_type KIND_WRITE    = 3'd0;
   localparam kind_type KIND_LENGTH   = 3'd1;
   localparam kind_type KIND_ENVELOPE = 3'd2;
   localparam kind_type KIND_ADVANCE  = 3'd3;
   localparam kind_type KIND_DISABLE  = 3'd4;

   localparam reg_index_type REG_LENGTH   = 2'd0;
   localparam reg_index_type REG_ENVELOPE = 2'd1;
   localparam reg_index_type REG_POLY     = 2'd2;
   localparam reg_index_type REG_CONTROL  = 2'd3;

   localparam logic [14:0] LFSR_SEED   = 15'h7FFF;
   localparam logic [6:0]  LENGTH_FULL = 7'd64;
   localparam logic [23:0] COUNT_MIN   = 24'h800000;

   typedef struct packed {
      kind_type      kind;
      reg_index_type reg_index;
      logic [7:0]    write_value;
      logic [11:0]   cycles;
   } item_type;

   typedef struct packed {
      logic [6:0]  length_left;
      logic [3:0]  start_volume;
      logic        envelope_up;
      logic [2:0]  envelope_sweep;
      logic [2:0]  envelope_count;
      logic [3:0]  volume;
      logic [3:0]  clock_shift;
      logic        short_mode;
      logic [21:0] period_value;
      logic [23:0] down_counter;
      logic [14:0] shift_reg;
      logic        channel_on;
      logic        length_stop;
      logic [3:0]  held_sample;
   } state_type;

   function automatic logic [6:0] divisor(input logic [2:0] sel);
      logic [6:0] d;
      case (sel)
         3'd0:    d = 7'd8;
         3'd1:    d = 7'd16;
         3'd2:    d = 7'd32;
         3'd3:    d = 7'd48;
         3'd4:    d = 7'd64;
         3'd5:    d = 7'd80;
         3'd6:    d = 7'd96;
         default: d = 7'd112;
      endcase
      return d;
   endfunction

endpackage

### hdl/ncle_req_if.sv
interface ncle_req_if;
   logic                    valid;
   logic                    ready;
   ncle_pkg::kind_type      kind;
   ncle_pkg::reg_index_type reg_index;
   logic [7:0]              write_value;
   logic [11:0]             cycles;

   modport source (output valid, kind, reg_index, write_value, cycles, input ready);
   modport sink (input valid, kind, reg_index, write_value, cycles, output ready);
endinterface

### hdl/ncle_rsp_if.sv
interface ncle_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample;
   logic       enabled;

   modport source (output valid, sample, enabled, input ready);
   modport sink (input valid, sample, enabled, output ready);
endinterface

### hdl/ncle_step.sv
module ncle_step (
   input  ncle_pkg::item_type  item,
   input  ncle_pkg::state_type cur,
   output ncle_pkg::state_type nxt
);

   logic [24:0] diff;
   logic [23:0] cnt_sat;
   logic        cnt_expired;
   logic        fb;
   logic [14:0] lfsr_shift;
   logic [14:0] lfsr_next;
   logic [3:0]  sample_new;
   logic [2:0]  env_cnt;
   logic [21:0] period_new;
   logic [6:0]  length_dec;

   // counter saturates at the most negative 24-bit value
   assign diff        = {cur.down_counter[23], cur.down_counter} - {13'd0, item.cycles};
   assign cnt_sat     = (diff[24:23] == 2'b10) ? ncle_pkg::COUNT_MIN : diff[23:0];
   assign cnt_expired = cnt_sat[23] || (cnt_sat == 24'd0);

   assign fb         = cur.shift_reg[0] ^ cur.shift_reg[1];
   assign lfsr_shift = {fb, cur.shift_reg[14:1]};
   assign lfsr_next  = cur.short_mode ? {lfsr_shift[14:7], fb, lfsr_shift[5:0]} : lfsr_shift;
   assign sample_new = (cur.channel_on && !lfsr_next[0]) ? cur.volume : 4'd0;

   assign env_cnt    = (cur.envelope_count != 3'd0) ? cur.envelope_count - 3'd1
                                                     : cur.envelope_count;
   assign period_new = {15'd0, ncle_pkg::divisor(item.write_value[2:0])}
                       << item.write_value[7:4];
   assign length_dec = (cur.length_left != 7'd0) ? cur.length_left - 7'd1 : cur.length_left;

   always_comb begin
      nxt = cur;
      case (item.kind)
         ncle_pkg::KIND_WRITE: begin
            case (item.reg_index)
               ncle_pkg::REG_LENGTH: begin
                  nxt.length_left = ncle_pkg::LENGTH_FULL - {1'b0, item.write_value[5:0]};
               end
               ncle_pkg::REG_ENVELOPE: begin
                  nxt.start_volume   = item.write_value[7:4];
                  nxt.envelope_up    = item.write_value[3];
                  nxt.envelope_sweep = item.write_value[2:0];
               end
               ncle_pkg::REG_POLY: begin
                  nxt.clock_shift  = item.write_value[7:4];
                  nxt.short_mode   = item.write_value[3];
                  nxt.period_value = period_new;
               end
               ncle_pkg::REG_CONTROL: begin
                  nxt.length_stop = item.write_value[6];
                  if (item.write_value[7]) begin
                     nxt.channel_on = 1'b1;
                     if (cur.length_left == 7'd0) begin
                        nxt.length_left = ncle_pkg::LENGTH_FULL;
                     end
                     nxt.volume         = cur.start_volume;
                     nxt.envelope_count = cur.envelope_sweep;
                     nxt.down_counter   = {2'b00, cur.period_value};
                     nxt.shift_reg      = ncle_pkg::LFSR_SEED;
                  end
               end
               default: begin
               end
            endcase
         end
         ncle_pkg::KIND_LENGTH: begin
            nxt.length_left = length_dec;
            if (length_dec == 7'd0 && cur.length_stop) begin
               nxt.channel_on = 1'b0;
            end
         end
         ncle_pkg::KIND_ENVELOPE: begin
            if (cur.envelope_sweep != 3'd0) begin
               nxt.envelope_count = env_cnt;
               if (env_cnt == 3'd0) begin
                  if (cur.envelope_up) begin
                     if (cur.volume != 4'hF) nxt.volume = cur.volume + 4'd1;
                  end else begin
                     if (cur.volume != 4'h0) nxt.volume = cur.volume - 4'd1;
                  end
                  nxt.envelope_count = cur.envelope_sweep;
               end
            end
         end
         ncle_pkg::KIND_ADVANCE: begin
            nxt.down_counter = cnt_sat;
            if (cnt_expired) begin
               nxt.down_counter = cnt_sat + {2'b00, cur.period_value};
               nxt.shift_reg    = lfsr_next;
               nxt.held_sample  = sample_new;
            end
         end
         ncle_pkg::KIND_DISABLE: begin
            nxt.channel_on = 1'b0;
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/noise_channel_lfsr_envelope.sv
// Noise channel: 15-bit LFSR with programmable period, volume envelope and
// length counter. Every item (register write, length tick, envelope tick,
// cycle advance or disable) yields one result item carrying the latched
// sample and the enable flag. One item is taken per clock while the result
// side does not stall; an accepted item passes through the input register,
// then the result register, before its result is presented. The channel state
// is updated once per item, and that loop sets the one-item-per-clock rate.
module noise_channel_lfsr_envelope (
   input  logic              clock,
   input  logic              reset,
   ncle_req_if.sink          req_ch,
   ncle_rsp_if.source        rsp_ch
);

   logic                s1_valid_ff;
   ncle_pkg::item_type  s1_item_ff;
   ncle_pkg::state_type state_ff;
   ncle_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_sample_ff;
   logic                rsp_enabled_ff;
   logic                s1_move;
   ncle_pkg::item_type  req_item;

   assign req_item = '{kind:        req_ch.kind,
                       reg_index:   req_ch.reg_index,
                       write_value: req_ch.write_value,
                       cycles:      req_ch.cycles};

   assign s1_move      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;

   ncle_step u_step (
      .item (s1_item_ff),
      .cur  (state_ff),
      .nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{shift_reg: ncle_pkg::LFSR_SEED, default: '0};
      end else if (s1_move) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_sample_ff  <= state_in.held_sample;
         rsp_enabled_ff <= state_in.channel_on;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.sample  = rsp_sample_ff;
   assign rsp_ch.enabled = rsp_enabled_ff;

`ifndef SYNTHESIS
   // advance items never touch the volume
   a_adv_keeps_volume: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_item_ff.kind == ncle_pkg::KIND_ADVANCE)
      |=> state_ff.volume == $past(state_ff.volume))
      else $error("volume changed on advance");

   // channel turns on only through a register write
   a_on_by_write: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $rose(state_ff.channel_on))
      |-> $past(s1_move && s1_item_ff.kind == ncle_pkg::KIND_WRITE))
      else $error("channel enabled without a write");

   // latched sample moves only on an advance
   a_sample_on_adv: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(state_ff.held_sample))
      |-> $past(s1_move && s1_item_ff.kind == ncle_pkg::KIND_ADVANCE))
      else $error("sample changed outside advance");

   // a new result is only ever loaded from the input stage
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $rose(rsp_valid_ff)) |-> $past(s1_valid_ff))
      else $error("result item without source item");
`endif

endmodule
